// ===== design/tct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tct_pkg;

    localparam int TCT_SLOTS = 20;

    localparam logic [31:0] U32_MAX       = 32'hFFFF_FFFF;
    localparam logic [63:0] NS_PER_SECOND = 64'd1000000000;
    localparam logic [29:0] NS_MULT       = 30'd1000000000;
    localparam logic [4:0]  DIV_LAST      = 5'd31;

    typedef enum logic [1:0] {
        FUNC_BEGIN  = 2'd0,
        FUNC_UPDATE = 2'd1,
        FUNC_END    = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic exec;
        logic mul;
        logic div;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic rate_due;
        logic div_done;
    } status_t;

    typedef struct packed {
        logic [15:0] dev;
        logic [31:0] touch;
        logic        rec;
        logic [31:0] cnt;
    } entry_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == U32_MAX) ? v : v + 32'd1;
    endfunction

    function automatic logic [31:0] sat_add2(input logic [31:0] v, input logic [1:0] n);
        logic [32:0] s;
        s = {1'b0, v} + 33'(n);
        return s[32] ? U32_MAX : s[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/touch_contact_tracker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Touch contact tracker. Each accepted item is one touch event (begin, update or end) and
// yields exactly one result item. The contact table is searched one slot per clock through
// a registered single-port table read. An update that closes a one-second rate window also
// runs the multiply and the bit-serial 32-step rate division before its result is published.
// Only one item is processed at a time. The result sits in an output register, and the next
// item is accepted and searched while that result waits to be taken.

module touch_contact_tracker_top #(
    parameter int SLOTS = tct_pkg::TCT_SLOTS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [15:0] s_source_dev,
    input  wire logic [31:0] s_touch_id,
    input  wire logic [63:0] s_timestamp_ns,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_slot,
    output logic             m_slot_valid,
    output logic             m_recovered,
    output logic [1:0]       m_sequence_error,
    output logic             m_dropped,
    output logic [31:0]      m_event_count,
    output logic [31:0]      m_contact_updates,
    output logic [4:0]       m_live_contacts,
    output logic [4:0]       m_peak_contacts,
    output logic [31:0]      m_total_errors,
    output logic [31:0]      m_total_dropped,
    output logic [31:0]      m_update_rate
);

    tct_pkg::cmd_t    cmd;
    tct_pkg::status_t status;

    tct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tct_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_func            (s_func),
        .s_source_dev      (s_source_dev),
        .s_touch_id        (s_touch_id),
        .s_timestamp_ns    (s_timestamp_ns),
        .m_slot            (m_slot),
        .m_slot_valid      (m_slot_valid),
        .m_recovered       (m_recovered),
        .m_sequence_error  (m_sequence_error),
        .m_dropped         (m_dropped),
        .m_event_count     (m_event_count),
        .m_contact_updates (m_contact_updates),
        .m_live_contacts   (m_live_contacts),
        .m_peak_contacts   (m_peak_contacts),
        .m_total_errors    (m_total_errors),
        .m_total_dropped   (m_total_dropped),
        .m_update_rate     (m_update_rate)
    );

    // A result without a slot never carries the recovered mark.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_slot_valid |-> !m_recovered)
        else $error("recovered mark on a result without a slot");

    // A dropped contact always counts at least one sequence error.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dropped |-> (m_sequence_error != 2'd0))
        else $error("dropped contact without a sequence error");

    // After an item is taken, the next one waits until the table search has run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready again directly after an accepted item");

endmodule

`default_nettype wire

// ===== design/tct_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tct_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire tct_pkg::status_t status,
    output tct_pkg::cmd_t         cmd
);

    tct_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tct_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tct_pkg::ST_IDLE: begin
                if (s_valid) state_next = tct_pkg::ST_SCAN;
            end
            tct_pkg::ST_SCAN: begin
                if (status.scan_done) state_next = tct_pkg::ST_EXEC;
            end
            tct_pkg::ST_EXEC: begin
                state_next = status.rate_due ? tct_pkg::ST_MUL : tct_pkg::ST_DONE;
            end
            tct_pkg::ST_MUL: begin
                state_next = tct_pkg::ST_DIV;
            end
            tct_pkg::ST_DIV: begin
                if (status.div_done) state_next = tct_pkg::ST_DONE;
            end
            tct_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = tct_pkg::ST_IDLE;
            end
            default: begin
                state_next = tct_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            tct_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            tct_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            tct_pkg::ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            tct_pkg::ST_MUL: begin
                cmd.mul = 1'b1;
            end
            tct_pkg::ST_DIV: begin
                cmd.div = 1'b1;
            end
            tct_pkg::ST_DONE: begin
                cmd.publish = !m_valid_reg || m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign m_valid_next = cmd.publish || (m_valid_reg && !m_ready);
    assign m_valid      = m_valid_reg;

endmodule

`default_nettype wire

// ===== design/tct_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tct_dp #(
    parameter int SLOTS = tct_pkg::TCT_SLOTS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire tct_pkg::cmd_t    cmd,
    output tct_pkg::status_t      status,
    input  wire logic [1:0]       s_func,
    input  wire logic [15:0]      s_source_dev,
    input  wire logic [31:0]      s_touch_id,
    input  wire logic [63:0]      s_timestamp_ns,
    output logic [4:0]            m_slot,
    output logic                  m_slot_valid,
    output logic                  m_recovered,
    output logic [1:0]            m_sequence_error,
    output logic                  m_dropped,
    output logic [31:0]           m_event_count,
    output logic [31:0]           m_contact_updates,
    output logic [4:0]            m_live_contacts,
    output logic [4:0]            m_peak_contacts,
    output logic [31:0]           m_total_errors,
    output logic [31:0]           m_total_dropped,
    output logic [31:0]           m_update_rate
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    // Captured item.
    tct_pkg::func_t func_reg;
    logic [15:0]    dev_reg;
    logic [31:0]    tid_reg;
    logic [63:0]    now_reg;

    // Slot table.
    tct_pkg::entry_t mem [SLOTS];
    tct_pkg::entry_t rd_entry_reg;
    logic            rd_busy_reg;
    logic            mem_we;
    logic [IDX_W-1:0] mem_waddr;
    tct_pkg::entry_t mem_wdata;
    logic [SLOTS-1:0] busy_reg, busy_next;

    // Scan.
    logic [CNT_W-1:0] scan_cnt_reg;
    logic             cmp_valid_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             issue, hit, cand;
    logic             found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic             match_rec_reg;
    logic [31:0]      match_cnt_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // Running state.
    logic [CNT_W-1:0] busy_count_reg, busy_count_next;
    logic [CNT_W-1:0] peak_reg, peak_next;
    logic [31:0] begin_total_reg, begin_total_next;
    logic [31:0] update_total_reg, update_total_next;
    logic [31:0] end_total_reg, end_total_next;
    logic [31:0] error_total_reg, error_total_next;
    logic [31:0] drop_total_reg, drop_total_next;
    logic [63:0] win_start_reg, win_start_next;
    logic [31:0] win_upd_reg, win_upd_next;
    logic [31:0] rate_reg, rate_next;

    // Per-item result.
    logic [IDX_W-1:0] res_slot_reg, res_slot_next;
    logic             res_valid_reg, res_valid_next;
    logic             res_rec_reg, res_rec_next;
    logic [1:0]       res_err_reg, res_err_next;
    logic             res_drop_reg, res_drop_next;
    logic [31:0]      res_count_reg, res_count_next;
    logic [31:0]      res_cu_reg, res_cu_next;

    // Rate division.
    logic [63:0] divisor_reg;
    logic [31:0] wu_div_reg;
    logic [63:0] rem_reg;
    logic [31:0] quo_reg, quo_next;
    logic [4:0]  div_cnt_reg;
    logic [61:0] product;
    logic [64:0] trial, diff;
    logic        ge;
    logic [63:0] rem_step;

    logic [63:0] start_eff, elapsed;
    logic [31:0] wu_new, cu_inc;
    logic        rate_due, alloc, cleared, drop;
    logic [1:0]  errs;

    // Output registers.
    logic [4:0]  m_slot_reg;
    logic        m_slot_valid_reg;
    logic        m_recovered_reg;
    logic [1:0]  m_sequence_error_reg;
    logic        m_dropped_reg;
    logic [31:0] m_event_count_reg;
    logic [31:0] m_contact_updates_reg;
    logic [4:0]  m_live_contacts_reg;
    logic [4:0]  m_peak_contacts_reg;
    logic [31:0] m_total_errors_reg;
    logic [31:0] m_total_dropped_reg;
    logic [31:0] m_update_rate_reg;

    assign issue = cmd.scan && (scan_cnt_reg != SLOTS_C);
    assign hit   = rd_busy_reg && (rd_entry_reg.dev == dev_reg)
                   && (rd_entry_reg.touch == tid_reg);
    assign cand  = !rd_busy_reg || ((func_reg == tct_pkg::FUNC_BEGIN) && hit);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg <= tct_pkg::func_t'(s_func);
            dev_reg  <= s_source_dev;
            tid_reg  <= s_touch_id;
            now_reg  <= s_timestamp_ns;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            rd_entry_reg <= mem[scan_cnt_reg[IDX_W-1:0]];
            rd_busy_reg  <= busy_reg[scan_cnt_reg[IDX_W-1:0]];
            cmp_idx_reg  <= scan_cnt_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            cmp_valid_reg <= issue;
            if (issue) begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
            if (cmd.capture) begin
                scan_cnt_reg   <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end else if (cmp_valid_reg) begin
                if (hit) found_reg <= 1'b1;
                if (cand) free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmp_valid_reg && hit && !found_reg) begin
            match_idx_reg <= cmp_idx_reg;
            match_rec_reg <= rd_entry_reg.rec;
            match_cnt_reg <= rd_entry_reg.cnt;
        end
        if (cmp_valid_reg && cand && !free_found_reg) begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    assign start_eff = (win_start_reg == 64'd0) ? now_reg : win_start_reg;
    assign elapsed   = now_reg - start_eff;
    assign wu_new    = tct_pkg::sat_inc(win_upd_reg);
    assign cu_inc    = tct_pkg::sat_inc(match_cnt_reg);

    assign product  = wu_div_reg * tct_pkg::NS_MULT;
    assign trial    = {rem_reg, quo_reg[31]};
    assign ge       = trial >= {1'b0, divisor_reg};
    assign diff     = trial - {1'b0, divisor_reg};
    assign rem_step = ge ? diff[63:0] : trial[63:0];
    assign quo_next = {quo_reg[30:0], ge};

    always_comb begin
        busy_next         = busy_reg;
        busy_count_next   = busy_count_reg;
        peak_next         = peak_reg;
        begin_total_next  = begin_total_reg;
        update_total_next = update_total_reg;
        end_total_next    = end_total_reg;
        error_total_next  = error_total_reg;
        drop_total_next   = drop_total_reg;
        win_start_next    = win_start_reg;
        win_upd_next      = win_upd_reg;
        rate_next         = rate_reg;
        res_slot_next     = res_slot_reg;
        res_valid_next    = res_valid_reg;
        res_rec_next      = res_rec_reg;
        res_err_next      = res_err_reg;
        res_drop_next     = res_drop_reg;
        res_count_next    = res_count_reg;
        res_cu_next       = res_cu_reg;
        mem_we            = 1'b0;
        mem_waddr         = free_idx_reg;
        mem_wdata.dev     = dev_reg;
        mem_wdata.touch   = tid_reg;
        mem_wdata.rec     = 1'b0;
        mem_wdata.cnt     = 32'd0;
        rate_due          = 1'b0;
        alloc             = 1'b0;
        cleared           = 1'b0;
        drop              = 1'b0;
        errs              = 2'd0;

        if (cmd.exec) begin
            res_slot_next  = '0;
            res_valid_next = 1'b0;
            res_rec_next   = 1'b0;
            res_count_next = 32'd0;
            res_cu_next    = 32'd0;
            unique case (func_reg)
                tct_pkg::FUNC_BEGIN: begin
                    begin_total_next = tct_pkg::sat_inc(begin_total_reg);
                    res_count_next   = begin_total_next;
                    if (found_reg) begin
                        errs                     = 2'd1;
                        cleared                  = 1'b1;
                        busy_next[match_idx_reg] = 1'b0;
                    end
                    if (free_found_reg) begin
                        alloc                   = 1'b1;
                        busy_next[free_idx_reg] = 1'b1;
                        mem_we                  = 1'b1;
                        res_slot_next           = free_idx_reg;
                        res_valid_next          = 1'b1;
                    end else begin
                        drop = 1'b1;
                        errs = errs + 2'd1;
                    end
                end
                tct_pkg::FUNC_UPDATE: begin
                    update_total_next = tct_pkg::sat_inc(update_total_reg);
                    res_count_next    = update_total_next;
                    if (elapsed >= tct_pkg::NS_PER_SECOND) begin
                        rate_due       = 1'b1;
                        win_start_next = now_reg;
                        win_upd_next   = 32'd0;
                    end else begin
                        win_start_next = start_eff;
                        win_upd_next   = wu_new;
                    end
                    if (found_reg) begin
                        mem_we         = 1'b1;
                        mem_waddr      = match_idx_reg;
                        mem_wdata.rec  = match_rec_reg;
                        mem_wdata.cnt  = cu_inc;
                        res_slot_next  = match_idx_reg;
                        res_valid_next = 1'b1;
                        res_rec_next   = match_rec_reg;
                        res_cu_next    = cu_inc;
                    end else if (free_found_reg) begin
                        errs                    = 2'd1;
                        alloc                   = 1'b1;
                        busy_next[free_idx_reg] = 1'b1;
                        mem_we                  = 1'b1;
                        mem_wdata.rec           = 1'b1;
                        mem_wdata.cnt           = 32'd1;
                        res_slot_next           = free_idx_reg;
                        res_valid_next          = 1'b1;
                        res_rec_next            = 1'b1;
                        res_cu_next             = 32'd1;
                    end else begin
                        errs = 2'd2;
                        drop = 1'b1;
                    end
                end
                tct_pkg::FUNC_END: begin
                    end_total_next = tct_pkg::sat_inc(end_total_reg);
                    res_count_next = end_total_next;
                    if (found_reg) begin
                        cleared                  = 1'b1;
                        busy_next[match_idx_reg] = 1'b0;
                        res_slot_next            = match_idx_reg;
                        res_valid_next           = 1'b1;
                        res_rec_next             = match_rec_reg;
                        res_cu_next              = match_cnt_reg;
                    end else begin
                        errs = 2'd1;
                    end
                end
                tct_pkg::FUNC_NONE: begin
                    errs = 2'd0;
                end
                default: begin
                    errs = 2'd0;
                end
            endcase
            busy_count_next  = busy_count_reg + CNT_W'(alloc) - CNT_W'(cleared);
            peak_next        = (busy_count_next > peak_reg) ? busy_count_next : peak_reg;
            error_total_next = tct_pkg::sat_add2(error_total_reg, errs);
            drop_total_next  = drop ? tct_pkg::sat_inc(drop_total_reg) : drop_total_reg;
            res_err_next     = errs;
            res_drop_next    = drop;
        end

        if (cmd.div && (div_cnt_reg == tct_pkg::DIV_LAST)) begin
            rate_next = quo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg         <= '0;
            busy_count_reg   <= '0;
            peak_reg         <= '0;
            begin_total_reg  <= 32'd0;
            update_total_reg <= 32'd0;
            end_total_reg    <= 32'd0;
            error_total_reg  <= 32'd0;
            drop_total_reg   <= 32'd0;
            win_start_reg    <= 64'd0;
            win_upd_reg      <= 32'd0;
            rate_reg         <= 32'd0;
            div_cnt_reg      <= 5'd0;
        end else begin
            busy_reg         <= busy_next;
            busy_count_reg   <= busy_count_next;
            peak_reg         <= peak_next;
            begin_total_reg  <= begin_total_next;
            update_total_reg <= update_total_next;
            end_total_reg    <= end_total_next;
            error_total_reg  <= error_total_next;
            drop_total_reg   <= drop_total_next;
            win_start_reg    <= win_start_next;
            win_upd_reg      <= win_upd_next;
            rate_reg         <= rate_next;
            if (cmd.mul) begin
                div_cnt_reg <= 5'd0;
            end else if (cmd.div) begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_slot_reg  <= res_slot_next;
        res_valid_reg <= res_valid_next;
        res_rec_reg   <= res_rec_next;
        res_err_reg   <= res_err_next;
        res_drop_reg  <= res_drop_next;
        res_count_reg <= res_count_next;
        res_cu_reg    <= res_cu_next;
        if (rate_due) begin
            divisor_reg <= elapsed;
            wu_div_reg  <= wu_new;
        end
        if (cmd.mul) begin
            rem_reg <= 64'(product[61:32]);
            quo_reg <= product[31:0];
        end else if (cmd.div) begin
            rem_reg <= rem_step;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_slot_reg            <= 5'(res_slot_reg);
            m_slot_valid_reg      <= res_valid_reg;
            m_recovered_reg       <= res_rec_reg;
            m_sequence_error_reg  <= res_err_reg;
            m_dropped_reg         <= res_drop_reg;
            m_event_count_reg     <= res_count_reg;
            m_contact_updates_reg <= res_cu_reg;
            m_live_contacts_reg   <= 5'(busy_count_reg);
            m_peak_contacts_reg   <= 5'(peak_reg);
            m_total_errors_reg    <= error_total_reg;
            m_total_dropped_reg   <= drop_total_reg;
            m_update_rate_reg     <= rate_reg;
        end
    end

    assign status.scan_done = (scan_cnt_reg == SLOTS_C) && !cmp_valid_reg;
    assign status.rate_due  = rate_due;
    assign status.div_done  = cmd.div && (div_cnt_reg == tct_pkg::DIV_LAST);

    assign m_slot            = m_slot_reg;
    assign m_slot_valid      = m_slot_valid_reg;
    assign m_recovered       = m_recovered_reg;
    assign m_sequence_error  = m_sequence_error_reg;
    assign m_dropped         = m_dropped_reg;
    assign m_event_count     = m_event_count_reg;
    assign m_contact_updates = m_contact_updates_reg;
    assign m_live_contacts   = m_live_contacts_reg;
    assign m_peak_contacts   = m_peak_contacts_reg;
    assign m_total_errors    = m_total_errors_reg;
    assign m_total_dropped   = m_total_dropped_reg;
    assign m_update_rate     = m_update_rate_reg;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS          = tct_pkg::TCT_SLOTS;
    localparam int RANDOM_EVENTS  = 1500;
    localparam int MAX_WAIT       = 18;
    localparam int TAIL_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 100;

    typedef struct packed {
        logic [4:0]  slot;
        logic        slot_valid;
        logic        recovered;
        logic [1:0]  sequence_error;
        logic        dropped;
        logic [31:0] event_count;
        logic [31:0] contact_updates;
        logic [4:0]  live_contacts;
        logic [4:0]  peak_contacts;
        logic [31:0] total_errors;
        logic [31:0] total_dropped;
        logic [31:0] update_rate;
    } contact_result_t;

    typedef struct packed {
        logic [1:0]      func;
        logic [15:0]     source_dev;
        logic [31:0]     touch_id;
        logic [63:0]     timestamp_ns;
        logic [4:0]      repeats;
        logic            typed;
        contact_result_t want;
    } plan_row_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func         = tct_pkg::FUNC_NONE;
    logic [15:0] s_source_dev   = '0;
    logic [31:0] s_touch_id     = '0;
    logic [63:0] s_timestamp_ns = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [4:0]  m_slot;
    logic        m_slot_valid;
    logic        m_recovered;
    logic [1:0]  m_sequence_error;
    logic        m_dropped;
    logic [31:0] m_event_count;
    logic [31:0] m_contact_updates;
    logic [4:0]  m_live_contacts;
    logic [4:0]  m_peak_contacts;
    logic [31:0] m_total_errors;
    logic [31:0] m_total_dropped;
    logic [31:0] m_update_rate;

    touch_contact_tracker_top u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_source_dev      (s_source_dev),
        .s_touch_id        (s_touch_id),
        .s_timestamp_ns    (s_timestamp_ns),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_slot            (m_slot),
        .m_slot_valid      (m_slot_valid),
        .m_recovered       (m_recovered),
        .m_sequence_error  (m_sequence_error),
        .m_dropped         (m_dropped),
        .m_event_count     (m_event_count),
        .m_contact_updates (m_contact_updates),
        .m_live_contacts   (m_live_contacts),
        .m_peak_contacts   (m_peak_contacts),
        .m_total_errors    (m_total_errors),
        .m_total_dropped   (m_total_dropped),
        .m_update_rate     (m_update_rate)
    );

    always #4 aclk = ~aclk;

    // Contact table and counters as the tracker should hold them.
    logic        occupied      [SLOTS];
    logic [15:0] owner_dev     [SLOTS];
    logic [31:0] owner_touch   [SLOTS];
    logic        was_recovered [SLOTS];
    logic [31:0] motion_count  [SLOTS];
    int          live_count    = 0;
    int          live_peak     = 0;
    logic [31:0] begins_seen   = '0;
    logic [31:0] updates_seen  = '0;
    logic [31:0] ends_seen     = '0;
    logic [31:0] errors_seen   = '0;
    logic [31:0] drops_seen    = '0;
    logic [31:0] win_updates   = '0;
    logic [63:0] win_start     = '0;
    logic [63:0] rate_now      = '0;

    contact_result_t pending_results [$];
    plan_row_t       plan [$];
    logic [63:0]     wall_ns      = '0;
    int              events_sent  = 0;
    int              results_seen = 0;
    int              fail_count   = 0;
    int              stall_cycles = 0;

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic int match_slot(input logic [15:0] dev, input logic [31:0] tid);
        for (int i = 0; i < SLOTS; i++) begin
            if (occupied[i] && owner_dev[i] == dev && owner_touch[i] == tid) return i;
        end
        return -1;
    endfunction

    function automatic int claim_slot(input logic [15:0] dev, input logic [31:0] tid,
                                      inout logic [1:0] errs, inout logic drop);
        for (int i = 0; i < SLOTS; i++) begin
            if (!occupied[i]) begin
                occupied[i]      = 1'b1;
                owner_dev[i]     = dev;
                owner_touch[i]   = tid;
                was_recovered[i] = 1'b0;
                motion_count[i]  = '0;
                live_count++;
                if (live_count > live_peak) live_peak = live_count;
                return i;
            end
        end
        drops_seen  = bump(drops_seen);
        errors_seen = bump(errors_seen);
        errs++;
        drop = 1'b1;
        return -1;
    endfunction

    function automatic contact_result_t track_event(input logic [1:0] f,
                                                    input logic [15:0] dev,
                                                    input logic [31:0] tid,
                                                    input logic [63:0] ts);
        contact_result_t r;
        logic [1:0]      errs;
        logic            drop;
        logic [63:0]     elapsed;
        int              s;
        r    = '0;
        errs = '0;
        drop = 1'b0;
        s    = -1;
        if (f != tct_pkg::FUNC_NONE) s = match_slot(dev, tid);
        case (f)
            tct_pkg::FUNC_BEGIN: begin
                begins_seen = bump(begins_seen);
                r.event_count = begins_seen;
                if (s >= 0) begin
                    errors_seen = bump(errors_seen);
                    errs++;
                    occupied[s] = 1'b0;
                    live_count--;
                end
                s = claim_slot(dev, tid, errs, drop);
            end
            tct_pkg::FUNC_UPDATE: begin
                updates_seen = bump(updates_seen);
                r.event_count = updates_seen;
                if (win_start == '0) win_start = ts;
                win_updates = bump(win_updates);
                elapsed = ts - win_start;
                if (elapsed >= tct_pkg::NS_PER_SECOND) begin
                    rate_now    = ({32'd0, win_updates} * tct_pkg::NS_PER_SECOND) / elapsed;
                    win_start   = ts;
                    win_updates = '0;
                end
                if (s < 0) begin
                    errors_seen = bump(errors_seen);
                    errs++;
                    s = claim_slot(dev, tid, errs, drop);
                    if (s >= 0) was_recovered[s] = 1'b1;
                end
                if (s >= 0) motion_count[s] = bump(motion_count[s]);
            end
            tct_pkg::FUNC_END: begin
                ends_seen = bump(ends_seen);
                r.event_count = ends_seen;
                if (s < 0) begin
                    errors_seen = bump(errors_seen);
                    errs++;
                end
            end
            default: ;
        endcase
        if (s >= 0) begin
            r.slot            = 5'(s);
            r.slot_valid      = 1'b1;
            r.recovered       = was_recovered[s];
            r.contact_updates = motion_count[s];
        end
        r.sequence_error = errs;
        r.dropped        = drop;
        if (f == tct_pkg::FUNC_END && s >= 0) begin
            occupied[s] = 1'b0;
            live_count--;
        end
        r.live_contacts = 5'(live_count);
        r.peak_contacts = 5'(live_peak);
        r.total_errors  = errors_seen;
        r.total_dropped = drops_seen;
        r.update_rate   = rate_now[31:0];
        return r;
    endfunction

    // Every fourth stretch of a hundred items runs without idling.
    function automatic int draw_wait(input int n);
        if ((n / 100) % 4 == 3) return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic offer_event(input logic [1:0] f, input logic [15:0] dev,
                               input logic [31:0] tid, input logic [63:0] ts,
                               input logic typed, input contact_result_t want);
        int              gap;
        contact_result_t predicted;
        gap = draw_wait(events_sent);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= f;
        s_source_dev   <= dev;
        s_touch_id     <= tid;
        s_timestamp_ns <= ts;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = track_event(f, dev, tid, ts);
        pending_results.push_back(typed ? want : predicted);
        events_sent++;
    endtask

    task automatic settle_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Mostly well-formed contact lifetimes; fill and drain phases alternate so the
    // table runs full and empty, with a little noise including the unused kind code.
    task automatic pick_event(input int n, output logic [1:0] f, output logic [15:0] dev,
                              output logic [31:0] tid, output logic [63:0] ts);
        int live[$];
        int r;
        int pick;
        int begin_share;
        for (int i = 0; i < SLOTS; i++) begin
            if (occupied[i]) live.push_back(i);
        end
        begin_share = ((n / 120) % 2 == 0) ? 45 : 15;
        dev  = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        tid  = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
        pick = (live.size() > 0) ? live[$urandom_range(0, live.size() - 1)] : -1;
        r    = $urandom_range(0, 99);
        if (r < begin_share) f = tct_pkg::FUNC_BEGIN;
        else if (r < 70) f = tct_pkg::FUNC_UPDATE;
        else if (r < 92) f = tct_pkg::FUNC_END;
        else if (r < 97) f = tct_pkg::FUNC_BEGIN;
        else begin
            f    = 2'($urandom_range(0, 3));
            pick = -1;
        end
        if (r >= begin_share && pick >= 0 && $urandom_range(0, 9) != 0) begin
            dev = owner_dev[pick];
            tid = owner_touch[pick];
        end
        r = $urandom_range(0, 99);
        if (r < 90) wall_ns = wall_ns + 64'($urandom_range(0, 60000000));
        else if (r < 97) wall_ns = wall_ns + 64'($urandom);
        else if (r < 99) wall_ns = {$urandom, $urandom};
        else wall_ns = '0;
        ts = wall_ns;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endtask

    initial begin
        logic [1:0]  f;
        logic [15:0] dev;
        logic [31:0] tid;
        logic [63:0] ts;
        for (int i = 0; i < SLOTS; i++) occupied[i] = 1'b0;

        plan.push_back('{tct_pkg::FUNC_BEGIN, 16'h0000, 32'h0, 64'h0, 5'd1, 1'b1,
                         '{5'd0, 1'b1, 1'b0, 2'd0, 1'b0, 32'd1, 32'd0, 5'd1, 5'd1,
                           32'd0, 32'd0, 32'd0}});
        plan.push_back('{tct_pkg::FUNC_UPDATE, 16'h0000, 32'h0, 64'h0, 5'd1, 1'b1,
                         '{5'd0, 1'b1, 1'b0, 2'd0, 1'b0, 32'd1, 32'd1, 5'd1, 5'd1,
                           32'd0, 32'd0, 32'd0}});
        plan.push_back('{tct_pkg::FUNC_END, 16'hFFFF, 32'hFFFF_FFFF, '1, 5'd1, 1'b1,
                         '{5'd0, 1'b0, 1'b0, 2'd1, 1'b0, 32'd1, 32'd0, 5'd1, 5'd1,
                           32'd1, 32'd0, 32'd0}});
        plan.push_back('{tct_pkg::FUNC_NONE, 16'hFFFF, 32'hFFFF_FFFF, '1, 5'd1, 1'b1,
                         '{5'd0, 1'b0, 1'b0, 2'd0, 1'b0, 32'd0, 32'd0, 5'd1, 5'd1,
                           32'd1, 32'd0, 32'd0}});
        plan.push_back('{tct_pkg::FUNC_BEGIN, 16'h0000, 32'h0, 64'd2, 5'd1, 1'b1,
                         '{5'd0, 1'b1, 1'b0, 2'd1, 1'b0, 32'd2, 32'd0, 5'd1, 5'd1,
                           32'd2, 32'd0, 32'd0}});
        plan.push_back('{tct_pkg::FUNC_UPDATE, 16'hFFFF, 32'hFFFF_FFFF, 64'd1,
                         5'd1, 1'b0, '0});
        plan.push_back('{tct_pkg::FUNC_BEGIN, 16'h1234, 32'd100, 64'd5, 5'd18, 1'b0, '0});
        plan.push_back('{tct_pkg::FUNC_BEGIN, 16'h0007, 32'd7, 64'd3, 5'd1, 1'b1,
                         '{5'd0, 1'b0, 1'b0, 2'd1, 1'b1, 32'd21, 32'd0, 5'd20, 5'd20,
                           32'd4, 32'd1, 32'd0}});
        plan.push_back('{tct_pkg::FUNC_UPDATE, 16'h0008, 32'd8, 64'd3, 5'd1, 1'b1,
                         '{5'd0, 1'b0, 1'b0, 2'd2, 1'b1, 32'd3, 32'd0, 5'd20, 5'd20,
                           32'd6, 32'd2, 32'd0}});
        plan.push_back('{tct_pkg::FUNC_UPDATE, 16'h0000, 32'h0, 64'd1000000001,
                         5'd1, 1'b0, '0});
        plan.push_back('{tct_pkg::FUNC_END, 16'h0000, 32'h0, 64'd1000000002,
                         5'd1, 1'b0, '0});
        plan.push_back('{tct_pkg::FUNC_END, 16'hFFFF, 32'hFFFF_FFFF, 64'd1000000003,
                         5'd1, 1'b0, '0});
        plan.push_back('{tct_pkg::FUNC_UPDATE, 16'h1234, 32'd100, 64'h0, 5'd1, 1'b0, '0});
        plan.push_back('{tct_pkg::FUNC_END, 16'h1234, 32'd100, 64'd10, 5'd18, 1'b0, '0});
        plan.push_back('{tct_pkg::FUNC_UPDATE, 16'h0005, 32'h8000_0000, '1, 5'd1, 1'b0, '0});
        plan.push_back('{tct_pkg::FUNC_BEGIN, 16'hAAAA, 32'h5555_5555, 64'h5555_5555_5555_5555,
                         5'd1, 1'b0, '0});
        plan.push_back('{tct_pkg::FUNC_UPDATE, 16'h5555, 32'hAAAA_AAAA,
                         64'hAAAA_AAAA_AAAA_AAAA, 5'd1, 1'b0, '0});
        plan.push_back('{tct_pkg::FUNC_NONE, 16'h0000, 32'h0, 64'h0, 5'd1, 1'b0, '0});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            for (int k = 0; k < int'(plan[i].repeats); k++) begin
                offer_event(plan[i].func, plan[i].source_dev, plan[i].touch_id + 32'(k),
                            plan[i].timestamp_ns, plan[i].typed, plan[i].want);
            end
        end
        settle_results();

        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            if (n == RANDOM_EVENTS / 2) settle_results();
            pick_event(n, f, dev, tid, ts);
            offer_event(f, dev, tid, ts, 1'b0, '0);
        end
        settle_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        int              gap;
        contact_result_t got;
        contact_result_t want;
        forever begin
            gap = draw_wait(results_seen);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got = '{m_slot, m_slot_valid, m_recovered, m_sequence_error, m_dropped,
                    m_event_count, m_contact_updates, m_live_contacts, m_peak_contacts,
                    m_total_errors, m_total_dropped, m_update_rate};
            if (pending_results.size() == 0) begin
                fail_count++;
                $error("Result item arrived with no expectation waiting.");
            end else begin
                want = pending_results.pop_front();
                compare_field("slot", 64'(want.slot), 64'(got.slot));
                compare_field("slot_valid", 64'(want.slot_valid), 64'(got.slot_valid));
                compare_field("recovered", 64'(want.recovered), 64'(got.recovered));
                compare_field("sequence_error", 64'(want.sequence_error),
                              64'(got.sequence_error));
                compare_field("dropped", 64'(want.dropped), 64'(got.dropped));
                compare_field("event_count", 64'(want.event_count), 64'(got.event_count));
                compare_field("contact_updates", 64'(want.contact_updates),
                              64'(got.contact_updates));
                compare_field("live_contacts", 64'(want.live_contacts),
                              64'(got.live_contacts));
                compare_field("peak_contacts", 64'(want.peak_contacts),
                              64'(got.peak_contacts));
                compare_field("total_errors", 64'(want.total_errors), 64'(got.total_errors));
                compare_field("total_dropped", 64'(want.total_dropped),
                              64'(got.total_dropped));
                compare_field("update_rate", 64'(want.update_rate), 64'(got.update_rate));
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
